[design/cka_pkg.sv]
package cka_pkg;

    localparam int PREP_STAGES = 3;
    localparam int DIV_W = 9;
    localparam int DIV_Q = 15;
    localparam int DIV_N = DIV_W + DIV_Q;
    localparam int LATENCY = PREP_STAGES + DIV_Q + 1 + DIV_Q + 1;

    typedef enum logic [2:0] {
        REG_HUE_LOW     = 3'd0,
        REG_HUE_HIGH    = 3'd1,
        REG_RAMP_LOW    = 3'd2,
        REG_RAMP_HIGH   = 3'd3,
        REG_SAT_LOW     = 3'd4,
        REG_VAL_LOW     = 3'd5,
        REG_SPILL_RED   = 3'd6,
        REG_SPILL_BLUE  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [8:0] hue_low;
        logic [8:0] hue_high;
        logic [8:0] ramp_low;
        logic [8:0] ramp_high;
        logic [8:0] sat_low;
        logic [7:0] val_low;
        logic [8:0] spill_red_weight;
        logic [8:0] spill_blue_weight;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        hue_low: 9'd80,
        hue_high: 9'd150,
        ramp_low: 9'd40,
        ramp_high: 9'd180,
        sat_low: 9'd102,
        val_low: 8'd77,
        spill_red_weight: 9'd128,
        spill_blue_weight: 9'd128
    };

    // Pixel data riding along with a division; key_ok is the saturation and
    // value result, fixed marks an alpha that needs no quotient.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       key_ok;
        logic       fixed;
    } side_t;

    // One restoring division step on the packed remainder and quotient word.
    function automatic logic [DIV_N-1:0] div_step(
        input logic [DIV_N-1:0] acc,
        input logic [DIV_W-1:0] den
    );
        logic [DIV_W:0] t;
        logic [DIV_W:0] dif;
        t = acc[DIV_N-1:DIV_Q-1];
        dif = t - {1'b0, den};
        if (!dif[DIV_W])
        begin
            return {dif[DIV_W-1:0], acc[DIV_Q-2:0], 1'b1};
        end
        return {t[DIV_W-1:0], acc[DIV_Q-2:0], 1'b0};
    endfunction

endpackage

[design/chroma_key_alpha_mask.sv]
// Chroma key with spill suppression. A pixel is taken at every clock edge at
// which start is high; busy is always low, so a new pixel may follow in every
// cycle. The result appears on the output ports with done high exactly 35
// cycles after the request was taken, in request order, and must be captured
// in that cycle because the block has no output stall. The latency is set by
// two 15-step pipelined dividers (hue, then alpha ramp) plus five register
// stages around them. Configuration is written through cfg_valid/cfg_ready,
// which is always ready, and should only change while no pixel is in flight.
module chroma_key_alpha_mask
    import cka_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] red_in,
    input  logic [7:0] green_in,
    input  logic [7:0] blue_in,
    output logic       done,
    output logic [7:0] red_out,
    output logic [7:0] green_out,
    output logic [7:0] blue_out,
    output logic [7:0] alpha_out,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [8:0] cfg_data
);

    cfg_t cfg_reg;

    logic             p_valid, h_valid, b_valid, a_valid;
    logic [DIV_N-1:0] p_num, b_num;
    logic [DIV_W-1:0] p_den, b_den;
    side_t            p_side, h_side, b_side, a_side;
    logic [DIV_Q-1:0] h_quo, a_quo;

    logic       done_reg;
    logic [7:0] red_reg, green_reg, blue_reg, alpha_reg;

    assign busy = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_idx_t'(cfg_index))
                REG_HUE_LOW:    cfg_reg.hue_low <= cfg_data;
                REG_HUE_HIGH:   cfg_reg.hue_high <= cfg_data;
                REG_RAMP_LOW:   cfg_reg.ramp_low <= cfg_data;
                REG_RAMP_HIGH:  cfg_reg.ramp_high <= cfg_data;
                REG_SAT_LOW:    cfg_reg.sat_low <= cfg_data;
                REG_VAL_LOW:    cfg_reg.val_low <= cfg_data[7:0];
                REG_SPILL_RED:  cfg_reg.spill_red_weight <= cfg_data;
                REG_SPILL_BLUE: cfg_reg.spill_blue_weight <= cfg_data;
                default: ;
            endcase
        end
    end

    cka_prep u_prep (
        .clk(clk), .rst_n(rst_n), .in_valid(start && !busy),
        .red(red_in), .green(green_in), .blue(blue_in), .cfg(cfg_reg),
        .out_valid(p_valid), .out_num(p_num), .out_den(p_den), .out_side(p_side)
    );

    cka_div_pipe u_hue_div (
        .clk(clk), .rst_n(rst_n), .in_valid(p_valid), .in_num(p_num),
        .in_den(p_den), .in_side(p_side),
        .out_valid(h_valid), .out_quo(h_quo), .out_side(h_side)
    );

    cka_band u_band (
        .clk(clk), .rst_n(rst_n), .in_valid(h_valid), .hue(h_quo),
        .in_side(h_side), .cfg(cfg_reg),
        .out_valid(b_valid), .out_num(b_num), .out_den(b_den), .out_side(b_side)
    );

    cka_div_pipe u_alpha_div (
        .clk(clk), .rst_n(rst_n), .in_valid(b_valid), .in_num(b_num),
        .in_den(b_den), .in_side(b_side),
        .out_valid(a_valid), .out_quo(a_quo), .out_side(a_side)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= a_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= a_side.red;
        green_reg <= a_side.green;
        blue_reg  <= a_side.blue;
        if (a_side.fixed)
            alpha_reg <= a_side.key_ok ? 8'd0 : 8'd255;
        else
            alpha_reg <= a_quo[7:0];
    end

    assign done      = done_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;
    assign alpha_out = alpha_reg;

`ifndef SYNTH
    a_request_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted request did not complete on time");
    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##LATENCY !done)
        else $error("result produced without a request");
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        h_valid |-> (h_quo < 15'd23040))
        else $error("hue out of range");
`endif

endmodule

[design/cka_div_pipe.sv]
module cka_div_pipe
    import cka_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [DIV_N-1:0] in_num,
    input  logic [DIV_W-1:0] in_den,
    input  side_t            in_side,
    output logic             out_valid,
    output logic [DIV_Q-1:0] out_quo,
    output side_t            out_side
);

    logic [DIV_Q-1:0] vld_reg;
    logic [DIV_N-1:0] acc_reg  [DIV_Q];
    logic [DIV_N-1:0] acc_next [DIV_Q];
    logic [DIV_W-1:0] den_reg  [DIV_Q];
    side_t            side_reg [DIV_Q];

    always_comb
    begin
        acc_next[0] = div_step(in_num, in_den);
        for (int k = 1; k < DIV_Q; k++)
        begin
            acc_next[k] = div_step(acc_reg[k-1], den_reg[k-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[DIV_Q-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg[0]  <= acc_next[0];
        den_reg[0]  <= in_den;
        side_reg[0] <= in_side;
        for (int k = 1; k < DIV_Q; k++)
        begin
            acc_reg[k]  <= acc_next[k];
            den_reg[k]  <= den_reg[k-1];
            side_reg[k] <= side_reg[k-1];
        end
    end

    assign out_valid = vld_reg[DIV_Q-1];
    assign out_quo   = acc_reg[DIV_Q-1][DIV_Q-1:0];
    assign out_side  = side_reg[DIV_Q-1];

`ifndef SYNTH
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (acc_reg[DIV_Q-1][DIV_N-1:DIV_Q] < den_reg[DIV_Q-1]))
        else $error("division remainder not below divisor");
`endif

endmodule

[design/cka_prep.sv]
module cka_prep
    import cka_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [7:0]       red,
    input  logic [7:0]       green,
    input  logic [7:0]       blue,
    input  cfg_t             cfg,
    output logic             out_valid,
    output logic [DIV_N-1:0] out_num,
    output logic [DIV_W-1:0] out_den,
    output side_t            out_side
);

    logic        v1_reg, v2_reg, v3_reg;
    logic [7:0]  r1_reg, g1_reg, b1_reg;
    logic [7:0]  r2_reg, g2_reg, b2_reg;
    logic [7:0]  mx2_reg, delta2_reg;
    logic [10:0] n2_reg;
    logic [16:0] pr2_reg, pb2_reg;
    logic [DIV_N-1:0] num3_reg;
    logic [DIV_W-1:0] den3_reg;
    side_t       side3_reg;

    logic [7:0]  mx, mn, delta;
    logic [10:0] n;
    logic [22:0] num;
    logic        sat_ok, val_ok;
    logic [17:0] limit;
    logic [7:0]  gout;

    always_comb
    begin
        mx = r1_reg;
        mn = r1_reg;
        if (g1_reg > mx) mx = g1_reg;
        if (b1_reg > mx) mx = b1_reg;
        if (g1_reg < mn) mn = g1_reg;
        if (b1_reg < mn) mn = b1_reg;
        delta = mx - mn;
        if (r1_reg == mx)
        begin
            if (g1_reg >= b1_reg)
                n = 11'(g1_reg - b1_reg);
            else
                n = 11'(11'(delta) * 11'd6 - 11'(b1_reg - g1_reg));
        end
        else if (g1_reg == mx)
        begin
            n = 11'(11'({delta, 1'b0}) + 11'(b1_reg) - 11'(r1_reg));
        end
        else
        begin
            n = 11'(11'({delta, 2'b0}) + 11'(r1_reg) - 11'(g1_reg));
        end
    end

    always_comb
    begin
        num = 23'({n2_reg, 12'b0}) - 23'({n2_reg, 8'b0});
        if (mx2_reg == 8'd0)
            sat_ok = (cfg.sat_low == 9'd0);
        else
            sat_ok = (17'({delta2_reg, 8'b0}) >= 17'(cfg.sat_low * mx2_reg));
        val_ok = (mx2_reg >= cfg.val_low);
        limit = 18'(pr2_reg) + 18'(pb2_reg);
        if (18'({g2_reg, 8'b0}) > limit)
            gout = limit[15:8];
        else
            gout = g2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        r1_reg <= red;
        g1_reg <= green;
        b1_reg <= blue;
        r2_reg <= r1_reg;
        g2_reg <= g1_reg;
        b2_reg <= b1_reg;
        mx2_reg <= mx;
        delta2_reg <= delta;
        n2_reg <= (delta == 8'd0) ? 11'd0 : n;
        pr2_reg <= 17'(cfg.spill_red_weight * r1_reg);
        pb2_reg <= 17'(cfg.spill_blue_weight * b1_reg);
        num3_reg <= DIV_N'(num);
        den3_reg <= (delta2_reg == 8'd0) ? DIV_W'(1) : DIV_W'(delta2_reg);
        side3_reg <= '{red: r2_reg, green: gout, blue: b2_reg,
                       key_ok: sat_ok && val_ok, fixed: 1'b0};
    end

    assign out_valid = v3_reg;
    assign out_num   = num3_reg;
    assign out_den   = den3_reg;
    assign out_side  = side3_reg;

endmodule

[design/cka_band.sv]
module cka_band
    import cka_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [DIV_Q-1:0] hue,
    input  side_t            in_side,
    input  cfg_t             cfg,
    output logic             out_valid,
    output logic [DIV_N-1:0] out_num,
    output logic [DIV_W-1:0] out_den,
    output side_t            out_side
);

    logic             v_reg;
    logic [DIV_N-1:0] num_reg;
    logic [DIV_W-1:0] den_reg;
    side_t            side_reg;

    logic [14:0] wl, wh, rl, rh, x;
    logic        hue_in, lower, upper;
    logic [22:0] prod;
    logic [8:0]  d;
    side_t       side;

    always_comb
    begin
        wl = {cfg.hue_low, 6'b0};
        wh = {cfg.hue_high, 6'b0};
        rl = {cfg.ramp_low, 6'b0};
        rh = {cfg.ramp_high, 6'b0};
        hue_in = (hue >= wl) && (hue <= wh);
        lower = (hue >= rl) && (hue < wl);
        upper = (hue > wh) && (hue <= rh);
        x = lower ? (wl - hue) : (hue - wh);
        d = lower ? (cfg.hue_low - cfg.ramp_low) : (cfg.ramp_high - cfg.hue_high);
        prod = 23'({x, 8'b0}) - 23'(x);
        side = in_side;
        side.fixed = 1'b0;
        if (hue_in)
        begin
            side.fixed = 1'b1;
        end
        else if (!lower && !upper)
        begin
            side.fixed = 1'b1;
            side.key_ok = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= side.fixed ? '0 : DIV_N'(prod[22:6]);
        den_reg  <= side.fixed ? DIV_W'(1) : d;
        side_reg <= side;
    end

    assign out_valid = v_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;

endmodule
